// ----- rtl/bass_enh_pkg.sv -----
// Package of the bass enhancer tap filter: constants, types, state codes and helpers.
`default_nettype none

package bass_enh_pkg;

    // Sizing
    localparam int LINE_DEPTH   = 512;
    localparam int MAX_TAPS     = 64;
    localparam int NUM_CHANNELS = 2;
    localparam int IDX_W        = $clog2(LINE_DEPTH);
    localparam int ADDR_W       = IDX_W + 1;
    localparam int MEM_DEPTH    = NUM_CHANNELS << IDX_W;
    localparam int TAP_W        = $clog2(MAX_TAPS + 1);
    localparam int WIX_W        = $clog2(MAX_TAPS);
    localparam int MIN_TAPS     = 8;
    localparam int TAP_SPACING  = 6;
    localparam int NUM_HP       = 2;
    localparam int NUM_STAGES   = 10;
    localparam int STG_W        = $clog2(NUM_STAGES);
    localparam int ODD_COEF     = 22938;
    localparam int DIV_STEPS    = 17;

    // Datapath widths
    localparam int MUL_A_W  = 38;
    localparam int MUL_B_W  = 26;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 50;
    localparam int WT_W     = 18;
    localparam int DIV_W    = 51;
    localparam int DEN_W    = 35;
    localparam int CFG_IX_W = 4;
    localparam int CFG_D_W  = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IX_W-1:0] {
        CFG_INPUT_GAIN  = 4'd0,
        CFG_OUTPUT_GAIN = 4'd1,
        CFG_DRIVE_GAIN  = 4'd2,
        CFG_TAP_COUNT   = 4'd3,
        CFG_PHASE_STEP  = 4'd4,
        CFG_WET_NORM    = 4'd5,
        CFG_HP_POLE     = 4'd6,
        CFG_LP_POLE     = 4'd7
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_W_Q,
        ST_W_DEN,
        ST_W_DIV,
        ST_W_SQ,
        ST_W_W,
        ST_W_ODD,
        ST_W_ODDW,
        ST_GAIN,
        ST_XWR,
        ST_T_A,
        ST_T_P,
        ST_T_MUL,
        ST_T_LAST,
        ST_N_MUL,
        ST_N_SAT,
        ST_P_M1,
        ST_P_M2,
        ST_P_UPD,
        ST_O_DRV,
        ST_O_Y,
        ST_O_MUL,
        ST_O_OUT
    } fsm_state_t;

    typedef struct packed {
        logic               chan;
        logic signed [23:0] sample_in;
        logic               last_chan;
    } in_beat_t;

    typedef struct packed {
        logic               chan_out;
        logic signed [23:0] sample_out;
    } out_beat_t;

    // Round half up then shift: floor(v / 2^n + 1/2)
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int n);
        logic signed [63:0] m;
        m = v + (64'sd1 <<< (n - 1));
        return m >>> n;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'sd8388607) begin
            r = 24'sh7F_FFFF;
        end else if (v < -64'sd8388608) begin
            r = 24'sh80_0000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic signed [MUL_A_W-1:0] sat_mul_a(input logic signed [63:0] v);
        logic signed [63:0]        hi;
        logic signed [63:0]        lo;
        logic signed [MUL_A_W-1:0] r;
        hi = (64'sd1 <<< (MUL_A_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            r = hi[MUL_A_W-1:0];
        end else if (v < lo) begin
            r = lo[MUL_A_W-1:0];
        end else begin
            r = v[MUL_A_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bass_enhancer_tap_filter_unit.sv -----
// Bass enhancer tap filter: sequencer, shared multiplier, delay line and filter states.
//
//  Channel | Direction | Ports                              | Carries
//  s_      | in        | s_valid, s_ready, s_data           | chan, sample_in, last_chan
//  m_      | out       | m_valid, m_ready, m_data           | chan_out, sample_out
//  cfg_    | in        | cfg_valid, cfg_ready, cfg_index/data | register writes, always taken
//
// Each item runs the tap loop (read a, read p, multiply per tap; taps = clamped tap_count),
// then the filter poles (two multiplies and an update each), paced by the single shared
// multiplier and the one-read delay line. After reset a clearing pass writes zeros to all
// MEM_DEPTH (1024) delay line entries; no beat is taken. The first item after reset or a
// phase_step write first rebuilds the weight table, each entry with a 17-step divider.
// s_ready is high only in idle; a finished result waits in the output register while the
// next beat is taken.
`default_nettype none

module bass_enhancer_tap_filter_unit
    import bass_enh_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire in_beat_t            s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output out_beat_t                m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_IX_W-1:0] cfg_index,
    input  wire logic [CFG_D_W-1:0]  cfg_data
);

    // Configuration registers
    logic [15:0]        input_gain_reg, output_gain_reg, drive_gain_reg, wet_norm_reg;
    logic [6:0]         tap_count_reg;
    logic [13:0]        phase_step_reg;
    logic [23:0]        hp_pole_reg, lp_pole_reg;

    // Control
    fsm_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic               wvalid_reg, wvalid_next;
    logic [IDX_W-1:0]   wi_reg, wi_next;
    logic               m_valid_reg, m_valid_next;
    logic [TAP_W-1:0]   k_reg, k_next;
    logic [WIX_W-1:0]   wk_reg, wk_next;
    logic [STG_W-1:0]   stg_reg, stg_next;
    logic [4:0]         dcnt_reg, dcnt_next;

    // Payload
    in_beat_t                  in_reg, in_next;
    logic                      ch_reg, ch_next;
    out_beat_t                 out_reg, out_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  sum_reg, sum_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [23:0]        x_reg, x_next;
    logic signed [23:0]        a_reg, a_next;
    logic signed [31:0]        wet_reg, wet_next;
    logic signed [MUL_A_W-1:0] y_reg, y_next;
    logic [IDX_W-1:0]          tix_reg, tix_next;
    logic [20:0]               tsum_reg, tsum_next;
    logic [DIV_W-1:0]          rem_reg, rem_next;
    logic [DIV_W-1:0]          dsh_reg, dsh_next;
    logic [16:0]               quot_reg, quot_next;
    logic [16:0]               w_reg, w_next;

    // Memories and their ports
    logic [23:0]             dline_mem [MEM_DEPTH];
    logic [23:0]             drd_reg;
    logic                    dwe;
    logic [ADDR_W-1:0]       dwa, dra;
    logic [23:0]             dwd;
    logic signed [WT_W-1:0]  wt_mem [MAX_TAPS];
    logic signed [WT_W-1:0]  wrd_reg;
    logic                    wwe;
    logic signed [WT_W-1:0]  wwd;

    // Filter states, one row per channel
    logic signed [31:0]      fst_reg [NUM_CHANNELS][NUM_STAGES];
    logic                    fwe;
    logic signed [31:0]      fwd;

    // Shared multiplier operands
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    // Helpers
    logic [TAP_W-1:0]   taps;
    logic               s_acc, m_acc;
    logic [15:0]        tphase;
    logic [23:0]        pole;
    logic [24:0]        pole_c;
    logic [IDX_W-1:0]   pix;
    logic signed [26:0] a_ext, p_ext, term;
    logic signed [63:0] tmp64;
    logic [33:0]        wsum;
    logic [30:0]        qv;
    logic [DEN_W-1:0]   den;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign s_acc     = s_valid && s_ready;
    assign m_acc     = m_valid_reg && m_ready;

    // Clamped tap count
    always_comb begin
        if (tap_count_reg < 7'(MIN_TAPS)) begin
            taps = TAP_W'(MIN_TAPS);
        end else if (tap_count_reg > 7'(MAX_TAPS)) begin
            taps = TAP_W'(MAX_TAPS);
        end else begin
            taps = TAP_W'(tap_count_reg);
        end
    end

    assign tphase = tsum_reg[16:1];
    assign pole   = (stg_reg < STG_W'(NUM_HP)) ? hp_pole_reg : lp_pole_reg;
    assign pole_c = 25'h100_0000 - {1'b0, pole};
    assign pix    = (tix_reg == '0) ? IDX_W'(LINE_DEPTH - 1) : tix_reg - 1'b1;
    assign a_ext  = {{3{a_reg[23]}}, a_reg};
    assign p_ext  = {{3{drd_reg[23]}}, drd_reg};
    assign term   = (p_ext <<< 1) + p_ext - ((a_ext <<< 2) + a_ext);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == ADDR_W'(MEM_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = wvalid_reg ? ST_GAIN : ST_W_Q;
                end
            end
            ST_W_Q:   state_next = ST_W_DEN;
            ST_W_DEN: state_next = ST_W_DIV;
            ST_W_DIV: begin
                if (dcnt_reg == '0) begin
                    state_next = ST_W_SQ;
                end
            end
            ST_W_SQ:  state_next = ST_W_W;
            ST_W_W: begin
                if (wk_reg[0]) begin
                    state_next = ST_W_ODD;
                end else if (wk_reg == WIX_W'(MAX_TAPS - 1)) begin
                    state_next = ST_GAIN;
                end else begin
                    state_next = ST_W_Q;
                end
            end
            ST_W_ODD: state_next = ST_W_ODDW;
            ST_W_ODDW: begin
                if (wk_reg == WIX_W'(MAX_TAPS - 1)) begin
                    state_next = ST_GAIN;
                end else begin
                    state_next = ST_W_Q;
                end
            end
            ST_GAIN:  state_next = ST_XWR;
            ST_XWR:   state_next = ST_T_A;
            ST_T_A:   state_next = ST_T_P;
            ST_T_P:   state_next = ST_T_MUL;
            ST_T_MUL: state_next = (k_reg + 1'b1 == taps) ? ST_T_LAST : ST_T_A;
            ST_T_LAST: state_next = ST_N_MUL;
            ST_N_MUL: state_next = ST_N_SAT;
            ST_N_SAT: state_next = ST_P_M1;
            ST_P_M1:  state_next = ST_P_M2;
            ST_P_M2:  state_next = ST_P_UPD;
            ST_P_UPD: begin
                state_next = (stg_reg == STG_W'(NUM_STAGES - 1)) ? ST_O_DRV : ST_P_M1;
            end
            ST_O_DRV: state_next = ST_O_Y;
            ST_O_Y:   state_next = ST_O_MUL;
            ST_O_MUL: state_next = ST_O_OUT;
            ST_O_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        clr_next     = clr_reg;
        wvalid_next  = wvalid_reg;
        wi_next      = wi_reg;
        m_valid_next = m_acc ? 1'b0 : m_valid_reg;
        k_next       = k_reg;
        wk_next      = wk_reg;
        stg_next     = stg_reg;
        dcnt_next    = dcnt_reg;
        in_next      = in_reg;
        ch_next      = ch_reg;
        out_next     = out_reg;
        sum_next     = sum_reg;
        acc_next     = acc_reg;
        x_next       = x_reg;
        a_next       = a_reg;
        wet_next     = wet_reg;
        y_next       = y_reg;
        tix_next     = tix_reg;
        tsum_next    = tsum_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        quot_next    = quot_reg;
        w_next       = w_reg;
        mul_a        = '0;
        mul_b        = '0;
        dwe          = 1'b0;
        dwa          = {ch_reg, wi_reg};
        dwd          = '0;
        dra          = {ch_reg, tix_reg};
        wwe          = 1'b0;
        wwd          = '0;
        fwe          = 1'b0;
        fwd          = '0;
        tmp64        = '0;
        wsum         = '0;
        qv           = '0;
        den          = '0;

        unique case (state_reg)
            // Zero the delay line after reset
            ST_CLEAR: begin
                dwe      = 1'b1;
                dwa      = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_acc) begin
                    in_next   = s_data;
                    ch_next   = (NUM_CHANNELS > 1) ? s_data.chan : 1'b0;
                    wk_next   = '0;
                    tsum_next = {7'b0, phase_step_reg};
                end
            end
            // Weight table: Bhaskara sine, squared; odd taps scaled by -0.35
            ST_W_Q: begin
                mul_a = MUL_A_W'({1'b0, tphase});
                mul_b = MUL_B_W'(17'h1_0000 - {1'b0, tphase});
            end
            ST_W_DEN: begin
                qv        = prod_reg[30:0];
                den       = DEN_W'(35'h5_0000_0000 - {2'b0, qv, 2'b0});
                rem_next  = {qv, 20'b0};
                dsh_next  = {den, 16'b0};
                quot_next = '0;
                dcnt_next = 5'(DIV_STEPS - 1);
            end
            ST_W_DIV: begin
                if (rem_reg >= dsh_reg) begin
                    rem_next  = rem_reg - dsh_reg;
                    quot_next = {quot_reg[15:0], 1'b1};
                end else begin
                    quot_next = {quot_reg[15:0], 1'b0};
                end
                dsh_next  = dsh_reg >> 1;
                dcnt_next = dcnt_reg - 1'b1;
            end
            ST_W_SQ: begin
                mul_a = MUL_A_W'({1'b0, quot_reg});
                mul_b = MUL_B_W'({1'b0, quot_reg});
            end
            ST_W_W: begin
                wsum   = {1'b0, prod_reg[32:0]} + 34'd32768;
                w_next = wsum[32:16];
                if (!wk_reg[0]) begin
                    wwe       = 1'b1;
                    wwd       = WT_W'({1'b0, wsum[32:16]});
                    wk_next   = wk_reg + 1'b1;
                    tsum_next = tsum_reg + {6'b0, phase_step_reg, 1'b0};
                    if (wk_reg == WIX_W'(MAX_TAPS - 1)) begin
                        wvalid_next = 1'b1;
                    end
                end
            end
            ST_W_ODD: begin
                mul_a = MUL_A_W'({1'b0, w_reg});
                mul_b = MUL_B_W'(ODD_COEF);
            end
            ST_W_ODDW: begin
                wsum      = {2'b0, prod_reg[31:0]} + 34'd32768;
                wwe       = 1'b1;
                wwd       = -WT_W'({2'b0, wsum[31:16]});
                wk_next   = wk_reg + 1'b1;
                tsum_next = tsum_reg + {6'b0, phase_step_reg, 1'b0};
                if (wk_reg == WIX_W'(MAX_TAPS - 1)) begin
                    wvalid_next = 1'b1;
                end
            end
            // Input gain, then store the sample
            ST_GAIN: begin
                mul_a = MUL_A_W'(in_reg.sample_in);
                mul_b = MUL_B_W'({1'b0, input_gain_reg});
            end
            ST_XWR: begin
                tmp64    = rshr(64'(prod_reg), 14);
                x_next   = sat24(tmp64);
                dwe      = 1'b1;
                dwa      = {ch_reg, wi_reg};
                dwd      = sat24(tmp64);
                acc_next = '0;
                k_next   = '0;
                tix_next = wi_reg;
            end
            // Tap loop: read a, read p, multiply by weight, accumulate
            ST_T_A: begin
                dra = {ch_reg, tix_reg};
                if (k_reg != '0) begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
            end
            ST_T_P: begin
                a_next = drd_reg;
                dra    = {ch_reg, pix};
            end
            ST_T_MUL: begin
                mul_a  = MUL_A_W'(term);
                mul_b  = MUL_B_W'(wrd_reg);
                k_next = k_reg + 1'b1;
                if (tix_reg < IDX_W'(TAP_SPACING)) begin
                    tix_next = tix_reg + IDX_W'(LINE_DEPTH - TAP_SPACING);
                end else begin
                    tix_next = tix_reg - IDX_W'(TAP_SPACING);
                end
            end
            ST_T_LAST: begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
            // Normalise; the rounded sum keeps its sign into the multiplier
            ST_N_MUL: begin
                tmp64 = rshr(64'(acc_reg), 18);
                mul_a = tmp64[MUL_A_W-1:0];
                mul_b = MUL_B_W'({1'b0, wet_norm_reg});
            end
            ST_N_SAT: begin
                wet_next = sat32(rshr(64'(prod_reg), 16));
                stg_next = '0;
            end
            // Two highpasses, eight lowpasses
            ST_P_M1: begin
                mul_a = MUL_A_W'(wet_reg);
                mul_b = MUL_B_W'({1'b0, pole_c});
            end
            ST_P_M2: begin
                sum_next = prod_reg;
                mul_a    = MUL_A_W'(fst_reg[ch_reg][stg_reg]);
                mul_b    = MUL_B_W'({1'b0, pole});
            end
            ST_P_UPD: begin
                fwe = 1'b1;
                fwd = sat32(rshr(64'(sum_reg) + 64'(prod_reg), 24));
                if (stg_reg < STG_W'(NUM_HP)) begin
                    wet_next = sat32(64'(wet_reg) - 64'(fwd));
                end else begin
                    wet_next = fwd;
                end
                stg_next = stg_reg + 1'b1;
            end
            // Dry plus driven wet, output gain
            ST_O_DRV: begin
                mul_a = MUL_A_W'(wet_reg);
                mul_b = MUL_B_W'({1'b0, drive_gain_reg});
            end
            ST_O_Y: begin
                y_next = sat_mul_a(64'(x_reg) + rshr(64'(prod_reg), 8));
            end
            ST_O_MUL: begin
                mul_a = y_reg;
                mul_b = MUL_B_W'({1'b0, output_gain_reg});
            end
            // Keep the product alive while the output register is busy
            ST_O_OUT: begin
                mul_a = y_reg;
                mul_b = MUL_B_W'({1'b0, output_gain_reg});
                if (!m_valid_reg || m_ready) begin
                    out_next.chan_out   = in_reg.chan;
                    out_next.sample_out = sat24(rshr(64'(prod_reg), 14));
                    m_valid_next        = 1'b1;
                    if (in_reg.last_chan) begin
                        wi_next = (wi_reg == IDX_W'(LINE_DEPTH - 1)) ? '0 : wi_reg + 1'b1;
                    end
                end
            end
            default: begin
                mul_a = '0;
            end
        endcase

        // A new phase step makes the weight table stale
        if (cfg_valid && cfg_index == CFG_PHASE_STEP) begin
            wvalid_next = 1'b0;
        end
    end

    assign prod_next = mul_a * mul_b;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            wvalid_reg  <= 1'b0;
            wi_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            wvalid_reg  <= wvalid_next;
            wi_reg      <= wi_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_gain_reg  <= 16'd16384;
            output_gain_reg <= 16'd16384;
            drive_gain_reg  <= 16'd5120;
            tap_count_reg   <= 7'd48;
            phase_step_reg  <= 14'd1365;
            wet_norm_reg    <= 16'd2399;
            hp_pole_reg     <= 24'd16677232;
            lp_pole_reg     <= 24'd16208148;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_INPUT_GAIN:  input_gain_reg  <= cfg_data[15:0];
                CFG_OUTPUT_GAIN: output_gain_reg <= cfg_data[15:0];
                CFG_DRIVE_GAIN:  drive_gain_reg  <= cfg_data[15:0];
                CFG_TAP_COUNT:   tap_count_reg   <= cfg_data[6:0];
                CFG_PHASE_STEP:  phase_step_reg  <= cfg_data[13:0];
                CFG_WET_NORM:    wet_norm_reg    <= cfg_data[15:0];
                CFG_HP_POLE:     hp_pole_reg     <= cfg_data[23:0];
                CFG_LP_POLE:     lp_pole_reg     <= cfg_data[23:0];
                default:         input_gain_reg  <= input_gain_reg;
            endcase
        end
    end

    // Filter states
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                for (int s = 0; s < NUM_STAGES; s++) begin
                    fst_reg[c][s] <= '0;
                end
            end
        end else if (fwe) begin
            fst_reg[ch_reg][stg_reg] <= fwd;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        wk_reg   <= wk_next;
        stg_reg  <= stg_next;
        dcnt_reg <= dcnt_next;
        in_reg   <= in_next;
        ch_reg   <= ch_next;
        out_reg  <= out_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        a_reg    <= a_next;
        wet_reg  <= wet_next;
        y_reg    <= y_next;
        tix_reg  <= tix_next;
        tsum_reg <= tsum_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
        w_reg    <= w_next;
    end

    // Delay line memory
    always_ff @(posedge aclk) begin
        if (dwe) begin
            dline_mem[dwa] <= dwd;
        end
        drd_reg <= dline_mem[dra];
    end

    // Weight table memory
    always_ff @(posedge aclk) begin
        if (wwe) begin
            wt_mem[wk_reg] <= wwd;
        end
        wrd_reg <= wt_mem[k_reg[WIX_W-1:0]];
    end

endmodule

`default_nettype wire
